/* rtl/ckd_pkg.sv */
// chorded keypad decoder package: word and state types, codes and key tables
// used by the interfaces, the decoder modules and the checker
// no dependencies
package ckd_pkg;

   // configuration port geometry
   localparam int CSR_AW = 2;
   localparam int CSR_DW = 32;
   localparam logic [CSR_AW-1:0] HOLD_RELOAD_ADDR = '0;
   localparam logic [6:0] HOLD_RELOAD_RESET = 7'd30;

   // hold counter repeat threshold sits this far below the reload value
   localparam logic signed [7:0] REPEAT_OFFSET = 8'sd10;

   // command codes
   localparam logic CMD_SCAN = 1'b0;
   localparam logic CMD_READ = 1'b1;

   // special key settings
   localparam logic [7:0] REPEAT_CODE = 8'd128;
   localparam logic [2:0] SHIFT_GROUP = 3'd4;

   typedef enum logic [1:0] {
      MODE_RELEASED            = 2'd0,
      MODE_DOUBLE              = 2'd1,
      MODE_SINGLE              = 2'd2,
      MODE_SINGLE_AFTER_DOUBLE = 2'd3
   } mode_type;

   typedef struct packed {
      logic              cmd;
      logic [7:0]        scan_map;
   } req_word_type;

   typedef struct packed {
      logic [7:0]        key_code;
      logic              key_ready;
      logic              shift_active;
   } rsp_word_type;

   typedef struct packed {
      logic [7:0]        prior_sample;
      logic [7:0]        accepted_map;
      mode_type          mode;
      logic              hit_pending;
      logic [2:0]        group_index;
      logic              shift_on;
      logic signed [7:0] hold_count;
      logic [7:0]        key_latch;
   } state_type;

   localparam state_type STATE_RESET = '{
      prior_sample: 8'd0,
      accepted_map: 8'd0,
      mode:         MODE_RELEASED,
      hit_pending:  1'b0,
      group_index:  3'd0,
      shift_on:     1'b0,
      hold_count:   8'sd0,
      key_latch:    8'd0
   };

   // code for a lone key release, by shift and group key
   localparam logic [7:0] LONE_ROM [0:1][0:7] = '{
      '{8'h08, 8'h0b, 8'h09, 8'h07, 8'h00, 8'h0a, 8'h20, 8'h0d},
      '{8'h08, 8'h0b, 8'h09, 8'h7f, 8'h00, 8'h0a, 8'h1b, 8'h0a}
   };

   // code for a two-key chord, by shift, group key and second key
   localparam logic [7:0] CHORD_ROM [0:1][0:7][0:7] = '{
      '{
         '{REPEAT_CODE, 8'h31, 8'h32, 8'h33, REPEAT_CODE, 8'h34, 8'h35, 8'h2d},
         '{8'h2e, 8'h11, 8'h2c, 8'h21, 8'h3a, 8'h10, 8'h3b, 8'h22},
         '{8'h61, 8'h62, 8'h73, 8'h63, 8'h64, 8'h65, 8'h73, 8'h66},
         '{8'h6d, 8'h6e, 8'h6f, 8'h7a, 8'h70, 8'h71, 8'h72, 8'h7a},
         '{8'h0f, 8'h36, 8'h37, 8'h38, 8'h0f, 8'h39, 8'h30, 8'h2b},
         '{8'h2a, 8'h0e, 8'h2f, 8'h24, 8'h28, 8'h0e, 8'h29, 8'h3d},
         '{8'h67, 8'h68, 8'h73, 8'h69, 8'h6a, 8'h6b, 8'h73, 8'h6c},
         '{8'h74, 8'h75, 8'h76, 8'h7a, 8'h77, 8'h78, 8'h79, 8'h7a}
      },
      '{
         '{8'h00, 8'h7c, 8'h40, 8'h23, 8'h00, 8'h34, 8'h35, 8'h2d},
         '{8'h7f, 8'h00, 8'h25, 8'h3f, 8'h7b, 8'h00, 8'h7d, 8'h27},
         '{8'h41, 8'h42, 8'h53, 8'h43, 8'h44, 8'h45, 8'h53, 8'h46},
         '{8'h4d, 8'h4e, 8'h4f, 8'h5a, 8'h50, 8'h51, 8'h52, 8'h5a},
         '{8'h00, 8'h36, 8'h37, 8'h38, 8'h00, 8'h39, 8'h3c, 8'h3e},
         '{8'h5e, 8'h00, 8'h5c, 8'h60, 8'h5b, 8'h00, 8'h5d, 8'h26},
         '{8'h47, 8'h48, 8'h53, 8'h49, 8'h4a, 8'h4b, 8'h53, 8'h4c},
         '{8'h54, 8'h55, 8'h56, 8'h5a, 8'h57, 8'h58, 8'h59, 8'h5a}
      }
   };

   // index of the highest set bit, zero for an empty map
   function automatic logic [2:0] top_bit(input logic [7:0] m);
      logic [2:0] r;
      r = 3'd0;
      for (int i = 1; i < 8; i++) begin
         if (m[i]) r = 3'(i);
      end
      return r;
   endfunction

endpackage

/* rtl/ckd_if.sv */
// chorded keypad decoder channel interfaces: request and response words
// with valid/ready handshake; depends on ckd_pkg
interface ckd_req_if;
   logic                  valid;
   logic                  ready;
   ckd_pkg::req_word_type data;

   modport source (output valid, output data, input ready);
   modport sink   (input valid, input data, output ready);
endinterface

interface ckd_rsp_if;
   logic                  valid;
   logic                  ready;
   ckd_pkg::rsp_word_type data;

   modport source (output valid, output data, input ready);
   modport sink   (input valid, input data, output ready);
endinterface

/* rtl/ckd_csr.sv */
// chorded keypad decoder register port: holds the hold counter reload value
// depends on ckd_pkg
module ckd_csr (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       csr_psel,
   input  logic                       csr_penable,
   input  logic                       csr_pwrite,
   input  logic [ckd_pkg::CSR_AW-1:0] csr_paddr,
   input  logic [ckd_pkg::CSR_DW-1:0] csr_pwdata,
   output logic [ckd_pkg::CSR_DW-1:0] csr_prdata,
   output logic                       csr_pready,
   output logic [6:0]                 hold_reload
);

   logic [6:0] reload_ff;
   logic [6:0] reload_in;
   logic       wr_hit;

   // write decode on the access phase
   assign wr_hit = csr_psel && csr_penable && csr_pwrite
                   && (csr_paddr == ckd_pkg::HOLD_RELOAD_ADDR);

   always_comb begin
      reload_in = reload_ff;
      if (wr_hit) reload_in = csr_pwdata[6:0];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         reload_ff <= ckd_pkg::HOLD_RELOAD_RESET;
      end else begin
         reload_ff <= reload_in;
      end
   end

   // readback
   always_comb begin
      csr_prdata = '0;
      if (csr_paddr == ckd_pkg::HOLD_RELOAD_ADDR) begin
         csr_prdata = {{(ckd_pkg::CSR_DW-7){1'b0}}, reload_ff};
      end
   end

   assign csr_pready  = 1'b1;
   assign hold_reload = reload_ff;

endmodule

/* rtl/ckd_state_mem.sv */
// chorded keypad decoder state memory: one-entry synchronous store with a
// registered read, write forwarding and a valid bit; depends on ckd_pkg
module ckd_state_mem (
   input  logic                clock,
   input  logic                reset,
   input  logic                wr_en,
   input  ckd_pkg::state_type  wr_data,
   output ckd_pkg::state_type  rd_data
);

   ckd_pkg::state_type state_mem [1];
   ckd_pkg::state_type rd_ff;
   logic               vld_ff;
   logic               vld_in;

   // storage write
   always_ff @(posedge clock) begin
      if (wr_en) state_mem[0] <= wr_data;
   end

   // registered read, a write in flight is forwarded to the next reader
   always_ff @(posedge clock) begin
      if (wr_en) begin
         rd_ff <= wr_data;
      end else begin
         rd_ff <= state_mem[0];
      end
   end

   assign vld_in = vld_ff || wr_en;

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= 1'b0;
      end else begin
         vld_ff <= vld_in;
      end
   end

   // entry not yet written reads as the reset state
   assign rd_data = vld_ff ? rd_ff : ckd_pkg::STATE_RESET;

endmodule

/* rtl/ckd_update.sv */
// chorded keypad decoder update logic: debounce, mode machine, hold counter
// and key lookup for one word; depends on ckd_pkg
module ckd_update (
   input  ckd_pkg::req_word_type word,
   input  ckd_pkg::state_type    cur,
   input  logic [6:0]            hold_reload,
   output ckd_pkg::state_type    nxt,
   output ckd_pkg::rsp_word_type rsp
);

   logic signed [7:0] reload_s;
   logic signed [7:0] threshold;
   logic [7:0]        map;
   logic [7:0]        rest;
   logic [7:0]        chord_code;
   logic [7:0]        out_code;
   logic              single_mode;

   assign map       = word.scan_map;
   assign reload_s  = $signed({1'b0, hold_reload});
   assign threshold = reload_s - ckd_pkg::REPEAT_OFFSET;

   // second key lookup, group key bit removed modulo 256
   assign rest        = map - (8'd1 << cur.group_index);
   assign chord_code  = ckd_pkg::CHORD_ROM[cur.shift_on][cur.group_index]
                                          [ckd_pkg::top_bit(rest)];
   assign single_mode = (cur.mode == ckd_pkg::MODE_SINGLE)
                        || (cur.mode == ckd_pkg::MODE_SINGLE_AFTER_DOUBLE);

   always_comb begin
      nxt      = cur;
      out_code = 8'd0;
      if (word.cmd == ckd_pkg::CMD_READ) begin
         // key read hands out the latch and clears the hit
         if (cur.hit_pending) begin
            out_code        = cur.key_latch;
            nxt.hit_pending = 1'b0;
         end
      end else begin
         if (map == cur.prior_sample) begin
            if (map == cur.accepted_map) begin
               // held map: hold counter and chord auto-repeat
               if (single_mode && !cur.hold_count[7]) begin
                  nxt.hold_count = cur.hold_count - 8'sd1;
               end else if (cur.mode == ckd_pkg::MODE_DOUBLE && !cur.hit_pending) begin
                  if (cur.hold_count >= threshold) begin
                     nxt.hold_count = cur.hold_count - 8'sd1;
                  end else begin
                     nxt.hold_count  = threshold;
                     nxt.hit_pending = 1'b1;
                  end
               end
            end else begin
               // accepted change
               nxt.accepted_map = map;
               if (!cur.hit_pending) begin
                  case (cur.mode)
                     ckd_pkg::MODE_DOUBLE: begin
                        if (map == 8'd0) begin
                           nxt.mode = ckd_pkg::MODE_RELEASED;
                        end else begin
                           nxt.group_index = ckd_pkg::top_bit(map);
                           nxt.mode        = ckd_pkg::MODE_SINGLE_AFTER_DOUBLE;
                        end
                     end
                     ckd_pkg::MODE_RELEASED: begin
                        nxt.group_index = ckd_pkg::top_bit(map);
                        nxt.mode        = ckd_pkg::MODE_SINGLE;
                     end
                     ckd_pkg::MODE_SINGLE: begin
                        if (map == 8'd0) begin
                           nxt.mode = ckd_pkg::MODE_RELEASED;
                           if (!cur.hold_count[7]) begin
                              if (cur.group_index == ckd_pkg::SHIFT_GROUP) begin
                                 nxt.shift_on = !cur.shift_on;
                              end else begin
                                 nxt.key_latch   = ckd_pkg::LONE_ROM[cur.shift_on]
                                                                    [cur.group_index];
                                 nxt.shift_on    = 1'b0;
                                 nxt.hit_pending = 1'b1;
                              end
                           end
                        end else begin
                           if (chord_code != ckd_pkg::REPEAT_CODE) begin
                              nxt.key_latch = chord_code;
                              nxt.shift_on  = 1'b0;
                           end
                           nxt.mode        = ckd_pkg::MODE_DOUBLE;
                           nxt.hit_pending = 1'b1;
                        end
                     end
                     default: begin
                        if (map == 8'd0) begin
                           nxt.mode = ckd_pkg::MODE_RELEASED;
                        end else begin
                           if (chord_code != ckd_pkg::REPEAT_CODE) begin
                              nxt.key_latch = chord_code;
                              nxt.shift_on  = 1'b0;
                           end
                           nxt.mode        = ckd_pkg::MODE_DOUBLE;
                           nxt.hit_pending = 1'b1;
                        end
                     end
                  endcase
               end
               nxt.hold_count = reload_s;
            end
         end
         nxt.prior_sample = map;
      end
   end

   assign rsp.key_code     = out_code;
   assign rsp.key_ready    = nxt.hit_pending;
   assign rsp.shift_active = nxt.shift_on;

endmodule

/* rtl/chorded_keypad_decoder_top.sv */
// Chorded keypad decoder, top level. Takes one word per clock cycle with no
// stalls of its own while the response side is ready: a request word is
// registered, then while it sits in the input register the decoder state is
// read from the one-entry state memory (a write from the word just before is
// forwarded), updated and written back, and the response word lands in an
// output register. The input register and output register let a new word
// enter while a response waits on rsp_chan.ready. The state memory has a
// valid bit and needs no clearing pass after reset. Register 0 at address 0
// holds the hold counter reload value (reset 30); write it only while no word
// is in flight.
// depends on ckd_pkg, ckd_if, ckd_csr, ckd_state_mem, ckd_update
module chorded_keypad_decoder_top (
   input  logic                       clock,
   input  logic                       reset,
   ckd_req_if.sink                    req_chan,
   ckd_rsp_if.source                  rsp_chan,
   input  logic                       csr_psel,
   input  logic                       csr_penable,
   input  logic                       csr_pwrite,
   input  logic [ckd_pkg::CSR_AW-1:0] csr_paddr,
   input  logic [ckd_pkg::CSR_DW-1:0] csr_pwdata,
   output logic [ckd_pkg::CSR_DW-1:0] csr_prdata,
   output logic                       csr_pready
);

   logic                  s_vld_ff;
   logic                  s_vld_in;
   ckd_pkg::req_word_type s_word_ff;
   logic                  o_vld_ff;
   logic                  o_vld_in;
   ckd_pkg::rsp_word_type o_word_ff;
   logic                  advance;
   logic                  req_take;
   logic [6:0]            hold_reload;
   ckd_pkg::state_type    cur_state;
   ckd_pkg::state_type    nxt_state;
   ckd_pkg::rsp_word_type rsp_word;

   ckd_csr u_csr (
      .clock       (clock),
      .reset       (reset),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready),
      .hold_reload (hold_reload)
   );

   // handshake and pipeline advance
   assign advance        = !o_vld_ff || rsp_chan.ready;
   assign req_chan.ready = !s_vld_ff || advance;
   assign req_take       = req_chan.valid && req_chan.ready;

   assign s_vld_in = (s_vld_ff && !advance) || req_take;
   assign o_vld_in = s_vld_ff || (o_vld_ff && !rsp_chan.ready);

   always_ff @(posedge clock) begin
      if (reset) begin
         s_vld_ff <= 1'b0;
         o_vld_ff <= 1'b0;
      end else begin
         s_vld_ff <= s_vld_in;
         o_vld_ff <= o_vld_in;
      end
   end

   // input word register
   always_ff @(posedge clock) begin
      if (req_take) s_word_ff <= req_chan.data;
   end

   // state read-modify-write
   ckd_state_mem u_state_mem (
      .clock   (clock),
      .reset   (reset),
      .wr_en   (s_vld_ff && advance),
      .wr_data (nxt_state),
      .rd_data (cur_state)
   );

   ckd_update u_update (
      .word        (s_word_ff),
      .cur         (cur_state),
      .hold_reload (hold_reload),
      .nxt         (nxt_state),
      .rsp         (rsp_word)
   );

   // output word register
   always_ff @(posedge clock) begin
      if (s_vld_ff && advance) o_word_ff <= rsp_word;
   end

   assign rsp_chan.valid = o_vld_ff;
   assign rsp_chan.data  = o_word_ff;

endmodule

/* rtl/ckd_checker.sv */
// chorded keypad decoder port checker and its bind to the top level
// depends on ckd_pkg and chorded_keypad_decoder_top
module ckd_checker (
   input logic                  clock,
   input logic                  reset,
   input logic                  req_valid,
   input logic                  req_ready,
   input logic                  rsp_valid,
   input logic                  rsp_ready,
   input ckd_pkg::rsp_word_type rsp_data
);

   // a stalled response word holds
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_data))
      else $error("response word changed while stalled");

   // a response only starts from an accepted request that has passed the input register
   a_rsp_source: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid) |-> $past(req_valid && req_ready, 2))
      else $error("response without a request");

   // a delivered key always clears the hit flag
   a_key_clears: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && (rsp_data.key_code != 8'd0) |-> !rsp_data.key_ready)
      else $error("key delivered with hit still pending");

   // an empty output register never blocks the request side
   a_ready_free: assert property (@(posedge clock) disable iff (reset)
      !rsp_valid |-> req_ready)
      else $error("request stalled with idle output");

endmodule

bind chorded_keypad_decoder_top ckd_checker u_ckd_checker (
   .clock     (clock),
   .reset     (reset),
   .req_valid (req_chan.valid),
   .req_ready (req_chan.ready),
   .rsp_valid (rsp_chan.valid),
   .rsp_ready (rsp_chan.ready),
   .rsp_data  (rsp_chan.data)
);
